// ===== hdl/smie_pkg.sv =====
// Shared types, opcodes and sizing constants of the stack machine instruction executor.
package smie_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int VAR_COUNT   = 64;
   localparam int LABEL_COUNT = 256;
   localparam int WORD_W      = 32;
   localparam int OPCODE_W    = 5;
   localparam int LABEL_W     = 8;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD_VAR   = 5'd0,
      OP_PUSH_IMM   = 5'd1,
      OP_STORE_KEEP = 5'd2,
      OP_STORE_POP  = 5'd3,
      OP_ADD        = 5'd4,
      OP_SUB        = 5'd5,
      OP_MUL        = 5'd6,
      OP_DIV        = 5'd7,
      OP_JUMP       = 5'd8,
      OP_JUMP_ZERO  = 5'd9,
      OP_EQ         = 5'd10,
      OP_NE         = 5'd11,
      OP_GT         = 5'd12,
      OP_LT         = 5'd13,
      OP_GE         = 5'd14,
      OP_LE         = 5'd15,
      OP_AND        = 5'd16,
      OP_OR         = 5'd17,
      OP_NOT        = 5'd18,
      OP_READ_INPUT = 5'd19,
      OP_PRINT      = 5'd20,
      OP_HALT       = 5'd21
   } opcode_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_DIV_ZERO  = 2'd3
   } error_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic signed [WORD_W-1:0] operand;
      logic signed [WORD_W-1:0] input_value;
   } req_type;

   typedef struct packed {
      logic                     branch_taken;
      logic [LABEL_W-1:0]       branch_label;
      logic                     print_valid;
      logic signed [WORD_W-1:0] print_value;
      logic                     halted;
      logic [1:0]               error_code;
   } rsp_type;

endpackage

// ===== hdl/stack_machine_instruction_executor_unit.sv =====
// Top level of the stack machine instruction executor: control, ALU and divider.
//
// Usage
//   req channel: one instruction per beat (opcode, operand, input_value).
//   rsp channel: one result beat per instruction (branch, print, halt, error).
//   Both channels use valid/stall; a beat moves when valid is high and stall low.
//   Sequence: an instruction is accepted, its stack and variable reads are
//   issued in the same cycle, and it executes in the next cycle in ST_EXEC,
//   where its result is registered into the result beat. No new beat is taken
//   until the last instruction has written its result.
//   Divide adds 32 steps of the bit-serial divider plus a write-back state.
//   When VAR_COUNT is not a power of two, instructions that index the variable
//   store first reduce the operand modulo VAR_COUNT by a reciprocal multiply,
//   remainder and correcting subtract in ST_INDEX, then read it in ST_READ.
//   The top of stack lives in a register; the entries below it live in the
//   stack RAM, and the second entry is read from it for every instruction.
//   Reset: synchronous, active high. After reset the block sweeps the variable
//   store to zero, one entry a cycle over all VAR_COUNT entries, with req_stall high.
//   Receiver stall: the result register holds its beat; the block still takes
//   one more instruction and waits before writing its result until the held
//   beat is taken.
module stack_machine_instruction_executor_unit #(
   parameter int STACK_DEPTH = smie_pkg::STACK_DEPTH,
   parameter int VAR_COUNT   = smie_pkg::VAR_COUNT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smie_pkg::rsp_type rsp_data
);

   localparam int WORD_W    = smie_pkg::WORD_W;
   localparam int LABEL_W   = smie_pkg::LABEL_W;
   localparam int STK_AW    = $clog2(STACK_DEPTH);
   localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int VAR_AW    = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
   localparam bit VAR_POW2  = ((VAR_COUNT & (VAR_COUNT - 1)) == 0);
   localparam int DIV_CNT_W = $clog2(WORD_W);
   // reciprocal of VAR_COUNT scaled so the quotient estimate is at most one low
   localparam int MOD_SHIFT = WORD_W + ((VAR_COUNT > 2) ? $clog2(VAR_COUNT) - 1 : 0);
   localparam logic [WORD_W-1:0] MOD_RECIP = WORD_W'((64'd1 << MOD_SHIFT) / VAR_COUNT);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_INDEX  = 7'b0000100,
      ST_READ   = 7'b0001000,
      ST_EXEC   = 7'b0010000,
      ST_DIVIDE = 7'b0100000,
      ST_DIV_WB = 7'b1000000
   } state_type;

   // control registers
   state_type             state_ff,     state_in;
   logic [CNT_W-1:0]      count_ff,     count_in;
   logic [VAR_AW-1:0]     clr_ff,       clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   smie_pkg::req_type     ins_ff,       ins_in;
   logic [VAR_AW-1:0]     vidx_ff,      vidx_in;
   logic [WORD_W-1:0]     tos_ff,       tos_in;
   logic [WORD_W-1:0]     div_rem_ff,   div_rem_in;
   logic [WORD_W-1:0]     div_quo_ff,   div_quo_in;
   logic [WORD_W-1:0]     div_dsr_ff,   div_dsr_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff,   div_cnt_in;
   logic                  div_neg_ff,   div_neg_in;
   smie_pkg::rsp_type     rsp_data_ff,  rsp_data_in;

   // memory ports
   logic                  stk_wr_en, stk_rd_en;
   logic [STK_AW-1:0]     stk_wr_addr, stk_rd_addr;
   logic [WORD_W-1:0]     stk_wr_data, stk_rd_data;
   logic                  var_wr_en, var_rd_en;
   logic [VAR_AW-1:0]     var_wr_addr, var_rd_addr;
   logic [WORD_W-1:0]     var_wr_data, var_rd_data;

   // handshake and decode of the incoming beat
   logic                  out_free;
   logic                  req_uses_var;
   logic                  req_needs_mod;
   logic [VAR_AW-1:0]     vidx_direct;
   smie_pkg::opcode_type  req_op;

   // count arithmetic
   logic [CNT_W-1:0]      cnt_m1, cnt_m2;
   logic                  has1, has2, full;

   // divider step
   logic [WORD_W:0]       div_trial;
   logic [WORD_W-1:0]     div_rem_step, div_quo_step;
   logic                  div_last;

   // variable index reduction
   logic [2*WORD_W-1:0]   mod_prod;
   logic [WORD_W-1:0]     mod_quo, mod_rem;

   // execute step
   smie_pkg::opcode_type  ex_op;
   logic [WORD_W-1:0]     ex_x, ex_y;
   logic [WORD_W-1:0]     ex_bin;
   logic [WORD_W-1:0]     ex_x_mag, ex_y_mag;
   logic [LABEL_W-1:0]    ex_label;
   smie_pkg::rsp_type     ex_rsp;
   logic [WORD_W-1:0]     ex_tos;
   logic [CNT_W-1:0]      ex_count;
   logic                  ex_stk_we;
   logic                  ex_var_we;
   logic [WORD_W-1:0]     ex_var_data;
   logic                  ex_div_go;

   smie_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   smie_ram #(.WIDTH(WORD_W), .DEPTH(VAR_COUNT)) u_var_ram (
      .clock   (clock),
      .wr_en   (var_wr_en),
      .wr_addr (var_wr_addr),
      .wr_data (var_wr_data),
      .rd_en   (var_rd_en),
      .rd_addr (var_rd_addr),
      .rd_data (var_rd_data)
   );

   // Variable index straight from the operand when the store size is a power of two;
   // otherwise a reciprocal multiply in ST_INDEX produces it.
   if (VAR_POW2) begin : g_vidx_mask
      assign vidx_direct = VAR_AW'($unsigned(req_data.operand) % WORD_W'(VAR_COUNT));
   end else begin : g_vidx_div
      assign vidx_direct = '0;
   end

   assign req_op       = smie_pkg::opcode_type'(req_data.opcode);
   assign req_uses_var = (req_op == smie_pkg::OP_LOAD_VAR)  || (req_op == smie_pkg::OP_STORE_KEEP) ||
                         (req_op == smie_pkg::OP_STORE_POP) || (req_op == smie_pkg::OP_READ_INPUT);
   assign req_needs_mod = !VAR_POW2 && req_uses_var;

   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // The top of stack is in tos_ff; stack RAM entry i holds stack entry i counted from the bottom.
   assign cnt_m1 = count_ff - CNT_W'(1);
   assign cnt_m2 = count_ff - CNT_W'(2);
   assign has1   = (count_ff != '0);
   assign has2   = (count_ff > CNT_W'(1));
   assign full   = (count_ff == CNT_W'(STACK_DEPTH));

   // Restoring divider: one quotient bit a cycle, remainder stays below the divisor.
   assign div_trial = {div_rem_ff, div_quo_ff[WORD_W-1]} - {1'b0, div_dsr_ff};
   assign div_last  = (div_cnt_ff == DIV_CNT_W'(WORD_W - 1));

   always_comb begin
      if (!div_trial[WORD_W]) begin
         div_rem_step = div_trial[WORD_W-1:0];
         div_quo_step = {div_quo_ff[WORD_W-2:0], 1'b1};
      end else begin
         div_rem_step = {div_rem_ff[WORD_W-2:0], div_quo_ff[WORD_W-1]};
         div_quo_step = {div_quo_ff[WORD_W-2:0], 1'b0};
      end
   end

   // Index reduction: quotient estimate (exact or one low), then the remainder,
   // which lies below twice VAR_COUNT.
   assign mod_prod = $unsigned(ins_ff.operand) * MOD_RECIP;
   assign mod_quo  = WORD_W'(mod_prod >> MOD_SHIFT);
   assign mod_rem  = $unsigned(ins_ff.operand) - WORD_W'(div_quo_ff * WORD_W'(VAR_COUNT));

   // Execute: x is the second entry from the RAM, y the top of stack.
   assign ex_op    = smie_pkg::opcode_type'(ins_ff.opcode);
   assign ex_x     = stk_rd_data;
   assign ex_y     = tos_ff;
   assign ex_x_mag = ex_x[WORD_W-1] ? (WORD_W'(0) - ex_x) : ex_x;
   assign ex_y_mag = ex_y[WORD_W-1] ? (WORD_W'(0) - ex_y) : ex_y;
   assign ex_label = LABEL_W'($unsigned(ins_ff.operand) % WORD_W'(smie_pkg::LABEL_COUNT));

   always_comb begin
      unique case (ex_op)
         smie_pkg::OP_ADD: ex_bin = ex_x + ex_y;
         smie_pkg::OP_SUB: ex_bin = ex_x - ex_y;
         smie_pkg::OP_MUL: ex_bin = ex_x * ex_y;
         smie_pkg::OP_EQ:  ex_bin = {{(WORD_W-1){1'b0}}, ex_x == ex_y};
         smie_pkg::OP_NE:  ex_bin = {{(WORD_W-1){1'b0}}, ex_x != ex_y};
         smie_pkg::OP_GT:  ex_bin = {{(WORD_W-1){1'b0}}, $signed(ex_x) > $signed(ex_y)};
         smie_pkg::OP_LT:  ex_bin = {{(WORD_W-1){1'b0}}, $signed(ex_x) < $signed(ex_y)};
         smie_pkg::OP_GE:  ex_bin = {{(WORD_W-1){1'b0}}, $signed(ex_x) >= $signed(ex_y)};
         smie_pkg::OP_LE:  ex_bin = {{(WORD_W-1){1'b0}}, $signed(ex_x) <= $signed(ex_y)};
         smie_pkg::OP_AND: ex_bin = {{(WORD_W-1){1'b0}}, (ex_x != '0) && (ex_y != '0)};
         smie_pkg::OP_OR:  ex_bin = {{(WORD_W-1){1'b0}}, (ex_x != '0) || (ex_y != '0)};
         default:          ex_bin = '0;
      endcase
   end

   always_comb begin
      ex_rsp      = '0;
      ex_tos      = tos_ff;
      ex_count    = count_ff;
      ex_stk_we   = 1'b0;
      ex_var_we   = 1'b0;
      ex_var_data = tos_ff;
      ex_div_go   = 1'b0;
      unique case (ex_op) inside
         smie_pkg::OP_LOAD_VAR, smie_pkg::OP_PUSH_IMM: begin
            if (full) begin
               ex_rsp.error_code = smie_pkg::ERR_OVERFLOW;
            end else begin
               // spill the old top below the new one
               ex_stk_we = has1;
               ex_tos    = (ex_op == smie_pkg::OP_LOAD_VAR) ? var_rd_data : ins_ff.operand;
               ex_count  = count_ff + CNT_W'(1);
            end
         end
         smie_pkg::OP_STORE_KEEP, smie_pkg::OP_STORE_POP, smie_pkg::OP_NOT,
         smie_pkg::OP_READ_INPUT, smie_pkg::OP_PRINT, smie_pkg::OP_JUMP_ZERO: begin
            if (!has1) begin
               ex_rsp.error_code = smie_pkg::ERR_UNDERFLOW;
            end else begin
               case (ex_op)
                  smie_pkg::OP_STORE_KEEP: begin
                     ex_var_we = 1'b1;
                  end
                  smie_pkg::OP_STORE_POP: begin
                     ex_var_we = 1'b1;
                     ex_tos    = ex_x;
                     ex_count  = cnt_m1;
                  end
                  smie_pkg::OP_NOT: begin
                     ex_tos = {{(WORD_W-1){1'b0}}, tos_ff == '0};
                  end
                  smie_pkg::OP_READ_INPUT: begin
                     ex_tos      = ins_ff.input_value;
                     ex_var_we   = 1'b1;
                     ex_var_data = ins_ff.input_value;
                  end
                  smie_pkg::OP_PRINT: begin
                     ex_rsp.print_valid = 1'b1;
                     ex_rsp.print_value = tos_ff;
                     ex_tos             = ex_x;
                     ex_count           = cnt_m1;
                  end
                  default: begin
                     // jump if zero: test and pop the top
                     if (tos_ff == '0) begin
                        ex_rsp.branch_taken = 1'b1;
                        ex_rsp.branch_label = ex_label;
                     end
                     ex_tos   = ex_x;
                     ex_count = cnt_m1;
                  end
               endcase
            end
         end
         smie_pkg::OP_ADD, smie_pkg::OP_SUB, smie_pkg::OP_MUL, smie_pkg::OP_DIV,
         smie_pkg::OP_EQ, smie_pkg::OP_NE, smie_pkg::OP_GT, smie_pkg::OP_LT,
         smie_pkg::OP_GE, smie_pkg::OP_LE, smie_pkg::OP_AND, smie_pkg::OP_OR: begin
            if (!has2) begin
               ex_rsp.error_code = smie_pkg::ERR_UNDERFLOW;
            end else if (ex_op == smie_pkg::OP_DIV) begin
               if (ex_y == '0) begin
                  ex_rsp.error_code = smie_pkg::ERR_DIV_ZERO;
               end else begin
                  ex_div_go = 1'b1;
               end
            end else begin
               ex_tos   = ex_bin;
               ex_count = cnt_m1;
            end
         end
         smie_pkg::OP_JUMP: begin
            ex_rsp.branch_taken = 1'b1;
            ex_rsp.branch_label = ex_label;
         end
         smie_pkg::OP_HALT: begin
            ex_rsp.halted = 1'b1;
         end
         default: begin
            // unknown opcode: no effect, all fields zero
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ins_in       = ins_ff;
      vidx_in      = vidx_ff;
      tos_in       = tos_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_dsr_in   = div_dsr_ff;
      div_cnt_in   = div_cnt_ff;
      div_neg_in   = div_neg_ff;
      rsp_data_in  = rsp_data_ff;

      stk_rd_en    = 1'b0;
      stk_rd_addr  = cnt_m2[STK_AW-1:0];
      stk_wr_en    = 1'b0;
      stk_wr_addr  = cnt_m1[STK_AW-1:0];
      stk_wr_data  = tos_ff;
      var_rd_en    = 1'b0;
      var_rd_addr  = (state_ff == ST_READ) ? vidx_ff : vidx_direct;
      var_wr_en    = 1'b0;
      var_wr_addr  = (state_ff == ST_CLEAR) ? clr_ff : vidx_ff;
      var_wr_data  = (state_ff == ST_CLEAR) ? '0 : ex_var_data;

      unique case (state_ff)
         ST_CLEAR: begin
            var_wr_en = 1'b1;
            clr_in    = clr_ff + VAR_AW'(1);
            if (clr_ff == VAR_AW'(VAR_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               ins_in = req_data;
               if (req_needs_mod) begin
                  div_cnt_in = '0;
                  state_in   = ST_INDEX;
               end else begin
                  vidx_in   = vidx_direct;
                  stk_rd_en = 1'b1;
                  var_rd_en = 1'b1;
                  state_in  = ST_EXEC;
               end
            end
         end
         ST_INDEX: begin
            // estimate the quotient, form the remainder, then correct it once
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               div_quo_in = mod_quo;
            end else if (div_cnt_ff == DIV_CNT_W'(1)) begin
               div_rem_in = mod_rem;
            end else begin
               vidx_in  = (div_rem_ff >= WORD_W'(VAR_COUNT)) ?
                          VAR_AW'(div_rem_ff - WORD_W'(VAR_COUNT)) : div_rem_ff[VAR_AW-1:0];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            stk_rd_en = 1'b1;
            var_rd_en = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            if (ex_div_go) begin
               div_rem_in = '0;
               div_quo_in = ex_x_mag;
               div_dsr_in = ex_y_mag;
               div_cnt_in = '0;
               div_neg_in = ex_x[WORD_W-1] ^ ex_y[WORD_W-1];
               state_in   = ST_DIVIDE;
            end else if (out_free) begin
               tos_in       = ex_tos;
               count_in     = ex_count;
               stk_wr_en    = ex_stk_we;
               var_wr_en    = ex_var_we;
               rsp_valid_in = 1'b1;
               rsp_data_in  = ex_rsp;
               state_in     = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            div_rem_in = div_rem_step;
            div_quo_in = div_quo_step;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_last) begin
               state_in = ST_DIV_WB;
            end
         end
         ST_DIV_WB: begin
            if (out_free) begin
               tos_in       = div_neg_ff ? (WORD_W'(0) - div_quo_ff) : div_quo_ff;
               count_in     = cnt_m1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ins_ff      <= ins_in;
      vidx_ff     <= vidx_in;
      tos_ff      <= tos_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_dsr_ff  <= div_dsr_in;
      div_cnt_ff  <= div_cnt_in;
      div_neg_ff  <= div_neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/smie_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smie_ram #(
   parameter int  WIDTH = smie_pkg::WORD_W,
   parameter int  DEPTH = smie_pkg::STACK_DEPTH,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/smie_checker.sv =====
// Port-level assertions for the stack machine instruction executor, bound to the top level.
module smie_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input smie_pkg::rsp_type rsp_data
);

   // come out of reset busy and with no result pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not busy or result pending after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // one instruction at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second instruction taken while one is in flight");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.error_code != smie_pkg::ERR_NONE) |->
         !rsp_data.branch_taken && !rsp_data.print_valid && !rsp_data.halted)
      else $error("failing instruction reported branch, print or halt");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.branch_taken || (rsp_data.branch_label == '0)) &&
         (rsp_data.print_valid || (rsp_data.print_value == '0)))
      else $error("label or print value nonzero without its flag");

endmodule

bind stack_machine_instruction_executor_unit smie_checker u_smie_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/tb_stack_machine_instruction_executor_unit.sv =====
// Self-checking testbench for the stack machine instruction executor unit.
`timescale 1ns / 1ps

module tb_stack_machine_instruction_executor_unit;
   import smie_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 6;
   // Slowest correct run: ~900 beats, each with a divide, a long sender gap and a
   // long receiver stall, plus the HOLD_CYCLES hold and the variable-store sweep
   // after reset. Take that several times over.
   localparam int CYCLE_LIMIT  = 500000;
   // Divide is the longest instruction.
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 400;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Shadow of the machine state, advanced once per accepted instruction beat.
   logic signed [WORD_W-1:0] stk_mem [STACK_DEPTH];
   int                       stk_depth;
   logic signed [WORD_W-1:0] var_mem [VAR_COUNT];

   // Expected result beats, oldest first.
   rsp_type pending_results[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int req_idle_pct   = 27;
   int rsp_idle_pct   = 45;
   int rsp_hold_left  = 0;

   stack_machine_instruction_executor_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   // Execute one instruction on the shadow state and return the result beat
   // it must produce. Erroring instructions touch neither stack nor store.
   function automatic rsp_type execute_instr(input req_type ins);
      rsp_type                  res;
      logic [WORD_W-1:0]        opnd;
      logic [WORD_W-1:0]        label_full;
      logic signed [WORD_W-1:0] x;
      logic signed [WORD_W-1:0] y;
      logic signed [WORD_W-1:0] calc;
      logic [WORD_W-1:0]        mag_x;
      logic [WORD_W-1:0]        mag_y;
      logic [WORD_W-1:0]        quo;
      int                       vidx;
      res        = '0;
      opnd       = ins.operand;
      // Variable and label indexes take the operand as unsigned.
      vidx       = int'(opnd % VAR_COUNT);
      label_full = opnd % LABEL_COUNT;
      case (ins.opcode)
         OP_LOAD_VAR, OP_PUSH_IMM: begin
            if (stk_depth >= STACK_DEPTH) begin
               res.error_code = ERR_OVERFLOW;
            end else begin
               stk_mem[stk_depth] = (ins.opcode == OP_LOAD_VAR) ? var_mem[vidx] : ins.operand;
               stk_depth++;
            end
         end
         OP_STORE_KEEP, OP_STORE_POP, OP_NOT, OP_READ_INPUT, OP_PRINT, OP_JUMP_ZERO: begin
            if (stk_depth < 1) begin
               res.error_code = ERR_UNDERFLOW;
            end else begin
               y = stk_mem[stk_depth-1];
               case (ins.opcode)
                  OP_STORE_KEEP: var_mem[vidx] = y;
                  OP_STORE_POP: begin
                     var_mem[vidx] = y;
                     stk_depth--;
                  end
                  OP_NOT: stk_mem[stk_depth-1] = (y == 0) ? 1 : 0;
                  OP_READ_INPUT: begin
                     stk_mem[stk_depth-1] = ins.input_value;
                     var_mem[vidx]        = ins.input_value;
                  end
                  OP_PRINT: begin
                     res.print_valid = 1'b1;
                     res.print_value = y;
                     stk_depth--;
                  end
                  default: begin
                     // jump-if-zero: always pops, branches only on a zero top
                     if (y == 0) begin
                        res.branch_taken = 1'b1;
                        res.branch_label = label_full[LABEL_W-1:0];
                     end
                     stk_depth--;
                  end
               endcase
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE,
         OP_AND, OP_OR: begin
            if (stk_depth < 2) begin
               res.error_code = ERR_UNDERFLOW;
            end else begin
               // x is the lower entry, y the former top
               y = stk_mem[stk_depth-1];
               x = stk_mem[stk_depth-2];
               if (ins.opcode == OP_DIV && y == 0) begin
                  res.error_code = ERR_DIV_ZERO;
               end else begin
                  case (ins.opcode)
                     OP_ADD: calc = x + y;
                     OP_SUB: calc = x - y;
                     OP_MUL: calc = x * y;
                     OP_DIV: begin
                        // Divide magnitudes, then fix the sign: truncates toward
                        // zero, and the most negative value over -1 wraps to itself.
                        mag_x = x[WORD_W-1] ? -x : x;
                        mag_y = y[WORD_W-1] ? -y : y;
                        quo   = mag_x / mag_y;
                        calc  = (x[WORD_W-1] ^ y[WORD_W-1]) ? -quo : quo;
                     end
                     OP_EQ:  calc = (x == y);
                     OP_NE:  calc = (x != y);
                     OP_GT:  calc = (x > y);
                     OP_LT:  calc = (x < y);
                     OP_GE:  calc = (x >= y);
                     OP_LE:  calc = (x <= y);
                     OP_AND: calc = (x != 0) && (y != 0);
                     default: calc = (x != 0) || (y != 0);
                  endcase
                  stk_mem[stk_depth-2] = calc;
                  stk_depth--;
               end
            end
         end
         OP_JUMP: begin
            res.branch_taken = 1'b1;
            res.branch_label = label_full[LABEL_W-1:0];
         end
         OP_HALT: res.halted = 1'b1;
         default: ;  // unknown code: no effect, all fields zero
      endcase
      return res;
   endfunction

   // Mix of extremes, small signed values and full-range words.
   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3, 4: return $urandom_range(16) - 8;
         default: return $urandom();
      endcase
   endfunction

   // Offer one instruction beat, idling first at random; hold it until taken,
   // then record its expected result. Leave valid high for a back-to-back beat.
   task automatic send_instr(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] opnd,
                             input logic [WORD_W-1:0] inval);
      req_type item;
      item.opcode      = op;
      item.operand     = opnd;
      item.input_value = inval;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(execute_instr(item));
   endtask

   // Compare one field of a result beat; report and count a mismatch.
   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver: stall at random, or hold off for a counted stretch on request.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Check every result beat taken against the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with none expected, expected none, actual %h",
                     $time, rsp_data);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("branch_taken", WORD_W'(want.branch_taken),
                        WORD_W'(rsp_data.branch_taken));
            check_field("branch_label", WORD_W'(want.branch_label),
                        WORD_W'(rsp_data.branch_label));
            check_field("print_valid", WORD_W'(want.print_valid),
                        WORD_W'(rsp_data.print_valid));
            check_field("print_value", want.print_value, rsp_data.print_value);
            check_field("halted", WORD_W'(want.halted), WORD_W'(rsp_data.halted));
            check_field("error_code", WORD_W'(want.error_code),
                        WORD_W'(rsp_data.error_code));
         end
      end
   end

   // Bound the run in case the block stops making progress.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
         $display("tb_stack_machine_instruction_executor_unit failed");
         $finish;
      end
   end

   // Empty stack after reset: every popping class underflows, non-stack
   // instructions still work, and the variable store reads back zero.
   task automatic test_empty_stack();
      send_instr(OP_PRINT, 0, 0);
      send_instr(OP_ADD, 0, 0);
      send_instr(OP_JUMP_ZERO, 3, 0);
      send_instr(OP_NOT, 0, 0);
      send_instr(OP_STORE_KEEP, 1, 0);
      send_instr(OP_READ_INPUT, 2, 32'h7fff_ffff);
      send_instr(OP_JUMP, '1, 0);              // label 255
      send_instr(OP_HALT, 0, 0);
      send_instr(5'h1f, '1, '1);               // unknown code, all ones
      send_instr(OP_LOAD_VAR, '1, 0);          // variable 63, cleared by reset
      send_instr(OP_DIV, 0, 0);                // one entry only: underflow
      send_instr(OP_PRINT, 0, 0);
   endtask

   // Wrapping arithmetic, signed division corners, compares, logic ops,
   // variable moves and both jump flavors on a short program.
   task automatic test_arith_and_flow();
      send_instr(OP_PUSH_IMM, 32'h7fff_ffff, 0);
      send_instr(OP_PUSH_IMM, 1, 0);
      send_instr(OP_ADD, 0, 0);                // wraps to most negative
      send_instr(OP_PUSH_IMM, -1, 0);
      send_instr(OP_DIV, 0, 0);                // most negative over -1
      send_instr(OP_PUSH_IMM, 0, 0);
      send_instr(OP_DIV, 0, 0);                // zero divisor: stack kept
      send_instr(OP_SUB, 0, 0);
      send_instr(OP_PUSH_IMM, -3, 0);
      send_instr(OP_MUL, 0, 0);
      send_instr(OP_PUSH_IMM, 7, 0);
      send_instr(OP_DIV, 0, 0);                // truncates toward zero
      send_instr(OP_PRINT, 0, 0);
      send_instr(OP_PUSH_IMM, -1, 0);
      send_instr(OP_PUSH_IMM, 1, 0);
      send_instr(OP_GT, 0, 0);                 // signed: false
      send_instr(OP_JUMP_ZERO, 300, 0);        // taken, label wraps
      send_instr(OP_PUSH_IMM, 2, 0);
      send_instr(OP_READ_INPUT, 63, 32'h8000_0000);
      send_instr(OP_LOAD_VAR, 63, 0);
      send_instr(OP_LE, 0, 0);
      send_instr(OP_NOT, 0, 0);
      send_instr(OP_STORE_KEEP, 5, 0);
      send_instr(OP_PUSH_IMM, 9, 0);
      send_instr(OP_OR, 0, 0);
      send_instr(OP_STORE_POP, 69, 0);         // index wraps to 5
   endtask

   // Hold the receiver off while pushing back to back: the block must fill
   // and stall its input. Push on until the stack is full, then overflow it.
   task automatic test_fill_under_hold();
      req_idle_pct  = 0;
      rsp_hold_left = HOLD_CYCLES;
      while (stk_depth < STACK_DEPTH)
         send_instr(OP_PUSH_IMM, random_word(), $urandom());
      send_instr(OP_PUSH_IMM, random_word(), $urandom());
      send_instr(OP_LOAD_VAR, random_word(), $urandom());
   endtask

   // Random programs: steer the stack toward a depth goal that moves now and
   // then, mostly shallow and sometimes past full, with a little noise.
   task automatic run_random_program(input int n_items, input int snd_idle, input int rcv_idle);
      int                  issued;
      int                  roll;
      int                  depth_goal;
      logic [OPCODE_W-1:0] op;
      req_idle_pct = snd_idle;
      rsp_idle_pct = rcv_idle;
      issued       = 0;
      depth_goal   = 4;
      while (issued < n_items) begin
         if (issued % 80 == 0)
            depth_goal = ($urandom_range(3) == 0) ? $urandom_range(8, STACK_DEPTH + 2)
                                                  : $urandom_range(2, 8);
         roll = $urandom_range(99);
         if (roll < 6)
            op = OPCODE_W'($urandom_range(31));   // noise, unknown codes included
         else if (stk_depth < depth_goal && roll < 70)
            op = ($urandom_range(3) == 0) ? OP_LOAD_VAR : OP_PUSH_IMM;
         else
            op = OPCODE_W'($urandom_range(OP_HALT));
         send_instr(op, random_word(), $urandom());
         if (op <= OP_HALT)
            issued++;
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      stk_depth = 0;
      foreach (stk_mem[i]) stk_mem[i] = '0;
      foreach (var_mem[i]) var_mem[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_empty_stack();
      test_arith_and_flow();
      test_fill_under_hold();
      run_random_program(280, 27, 45);
      run_random_program(280, 45, 27);
      run_random_program(190, 0, 0);

      // Drop valid, wait for the last result, then watch for stray beats.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("tb_stack_machine_instruction_executor_unit passed");
      else
         $display("tb_stack_machine_instruction_executor_unit failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/smie_pkg.sv
hdl/smie_ram.sv
hdl/stack_machine_instruction_executor_unit.sv
hdl/smie_checker.sv
tb/tb_stack_machine_instruction_executor_unit.sv
